>>> rtl/nfc_rfr_pkg.sv
// Shared constants, codes and a helper function of the response frame receiver.
package nfc_rfr_pkg;

   // Frame phase codes
   localparam logic [3:0] PH_PRE0  = 4'd0;
   localparam logic [3:0] PH_PRE1  = 4'd1;
   localparam logic [3:0] PH_START = 4'd2;
   localparam logic [3:0] PH_LEN   = 4'd3;
   localparam logic [3:0] PH_LCS   = 4'd4;
   localparam logic [3:0] PH_TFI   = 4'd5;
   localparam logic [3:0] PH_CMD   = 4'd6;
   localparam logic [3:0] PH_DATA  = 4'd7;
   localparam logic [3:0] PH_DCS   = 4'd8;
   localparam logic [3:0] PH_POST  = 4'd9;

   // Result kinds
   localparam logic [1:0] KIND_PROGRESS = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
   localparam logic [1:0] KIND_DONE     = 2'd2;
   localparam logic [1:0] KIND_FAIL     = 2'd3;

   // Status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_TIMEOUT   = 3'd1;
   localparam logic [2:0] STAT_INVALID   = 3'd2;
   localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
   localparam logic [2:0] STAT_BAD_ACK   = 3'd4;

   // Input actions
   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_TIMEOUT = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_EXPECTED_COMMAND = 2'd0;
   localparam logic [1:0] CSR_BUFFER_CAPACITY  = 2'd1;
   localparam logic [1:0] CSR_EXPECT_ACK       = 2'd2;

   // Frame bytes
   localparam logic [7:0] PREAMBLE_BYTE   = 8'h00;
   localparam logic [7:0] START_CODE_BYTE = 8'hFF;
   localparam logic [7:0] POSTAMBLE_BYTE  = 8'h00;
   localparam logic [7:0] DIR_TO_HOST     = 8'hD5;
   localparam logic [7:0] LEN_OVERHEAD    = 8'd2;
   localparam logic [2:0] ACK_LEN         = 3'd6;

   // Reset values of the registers
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'd0;
   localparam logic [7:0] BUFFER_CAPACITY_RESET  = 8'd64;

   // Acknowledge pattern 00 00 FF 00 FF 00
   function automatic logic [7:0] ack_pattern_byte(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd2, 3'd4: value = 8'hFF;
         default:    value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

>>> rtl/nfc_response_frame_receiver.sv
// Response frame receiver: checks one reader-to-host frame byte by byte.
//
// Each request carries a received serial byte or a receive timeout and yields exactly
// one response: progress, a payload byte, frame finished (with payload length) or frame
// failed (timeout, invalid frame, no space, invalid ack). Payload bytes go out as they
// arrive, before the data checksum is known; a later failure tells the user to discard
// them. Throughput is one request per clock cycle while the response channel keeps taking
// responses; the request enters the input register at the accepting edge and its response
// enters the result register once the result slot is free.
// The frame state update is a single small step from the input register, so the only
// limit on the rate is the response channel: while a response waits, one more request
// is still taken into the input register. Writes to the configuration port are always
// taken; writing the acknowledge mode bit restarts frame reception. Write configuration
// only while no request is in flight.
module nfc_response_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_payload_length,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // configuration registers
   logic [7:0] expected_command_ff;
   logic [7:0] buffer_capacity_ff;
   logic       expect_ack_ff;

   // input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   // frame state
   logic [3:0] phase_ff,       phase_in;
   logic [7:0] length_byte_ff, length_byte_in;
   logic [7:0] remaining_ff,   remaining_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [2:0] ack_index_ff,   ack_index_in;

   // result register
   logic       out_valid_ff;
   logic [1:0] kind_ff,   kind_in;
   logic [7:0] data_ff,   data_in;
   logic [2:0] status_ff, status_in;
   logic [7:0] plen_ff,   plen_in;

   logic       advance;
   logic       csr_write;
   logic [7:0] cmd;
   logic [7:0] len_sum;
   logic [7:0] payload_len;
   logic [2:0] ack_idx;
   logic       ack_mismatch;
   logic       fail;

   // move the input register into the result register when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign cmd         = expected_command_ff + 8'd1;
   assign len_sum     = length_byte_ff + in_byte_ff;
   assign payload_len = length_byte_ff - nfc_rfr_pkg::LEN_OVERHEAD;
   assign ack_idx     = (ack_index_ff >= nfc_rfr_pkg::ACK_LEN) ? 3'd0 : ack_index_ff;
   assign ack_mismatch = in_byte_ff != nfc_rfr_pkg::ack_pattern_byte(ack_idx);

   // next frame state and the response for the request in the input register
   always_comb begin
      phase_in       = phase_ff;
      length_byte_in = length_byte_ff;
      remaining_in   = remaining_ff;
      running_sum_in = running_sum_ff;
      ack_index_in   = ack_index_ff;
      kind_in        = nfc_rfr_pkg::KIND_PROGRESS;
      data_in        = 8'd0;
      status_in      = nfc_rfr_pkg::STAT_OK;
      plen_in        = 8'd0;
      fail           = 1'b0;

      if (in_action_ff == nfc_rfr_pkg::ACT_TIMEOUT) begin
         fail      = 1'b1;
         status_in = nfc_rfr_pkg::STAT_TIMEOUT;
      end else if (expect_ack_ff) begin
         // keep a sticky mismatch flag in the running sum, judge after the last byte
         if (ack_idx == nfc_rfr_pkg::ACK_LEN - 3'd1) begin
            if (ack_mismatch || running_sum_ff != 8'd0) begin
               fail      = 1'b1;
               status_in = nfc_rfr_pkg::STAT_BAD_ACK;
            end else begin
               phase_in       = nfc_rfr_pkg::PH_PRE0;
               length_byte_in = 8'd0;
               remaining_in   = 8'd0;
               running_sum_in = 8'd0;
               ack_index_in   = 3'd0;
               kind_in        = nfc_rfr_pkg::KIND_DONE;
            end
         end else begin
            ack_index_in = ack_idx + 3'd1;
            if (ack_mismatch) begin
               running_sum_in = 8'd1;
            end
         end
      end else begin
         unique case (phase_ff)
            nfc_rfr_pkg::PH_PRE1: begin
               if (in_byte_ff != nfc_rfr_pkg::PREAMBLE_BYTE) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  phase_in = nfc_rfr_pkg::PH_START;
               end
            end
            nfc_rfr_pkg::PH_START: begin
               if (in_byte_ff != nfc_rfr_pkg::START_CODE_BYTE) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  phase_in = nfc_rfr_pkg::PH_LEN;
               end
            end
            nfc_rfr_pkg::PH_LEN: begin
               length_byte_in = in_byte_ff;
               phase_in       = nfc_rfr_pkg::PH_LCS;
            end
            nfc_rfr_pkg::PH_LCS: begin
               if (len_sum != 8'd0 || length_byte_ff < nfc_rfr_pkg::LEN_OVERHEAD) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else if (payload_len > buffer_capacity_ff) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_NO_SPACE;
               end else begin
                  remaining_in = payload_len;
                  phase_in     = nfc_rfr_pkg::PH_TFI;
               end
            end
            nfc_rfr_pkg::PH_TFI: begin
               if (in_byte_ff != nfc_rfr_pkg::DIR_TO_HOST) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  phase_in = nfc_rfr_pkg::PH_CMD;
               end
            end
            nfc_rfr_pkg::PH_CMD: begin
               if (in_byte_ff != cmd) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  running_sum_in = nfc_rfr_pkg::DIR_TO_HOST + cmd;
                  phase_in = (remaining_ff != 8'd0) ? nfc_rfr_pkg::PH_DATA
                                                    : nfc_rfr_pkg::PH_DCS;
               end
            end
            nfc_rfr_pkg::PH_DATA: begin
               // release the byte now, the checksum verdict comes at the postamble
               running_sum_in = running_sum_ff + in_byte_ff;
               remaining_in   = remaining_ff - 8'd1;
               if (remaining_ff == 8'd1) begin
                  phase_in = nfc_rfr_pkg::PH_DCS;
               end
               kind_in = nfc_rfr_pkg::KIND_PAYLOAD;
               data_in = in_byte_ff;
            end
            nfc_rfr_pkg::PH_DCS: begin
               running_sum_in = running_sum_ff + in_byte_ff;
               phase_in       = nfc_rfr_pkg::PH_POST;
            end
            nfc_rfr_pkg::PH_POST: begin
               if (running_sum_ff != 8'd0 || in_byte_ff != nfc_rfr_pkg::POSTAMBLE_BYTE) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  phase_in       = nfc_rfr_pkg::PH_PRE0;
                  length_byte_in = 8'd0;
                  remaining_in   = 8'd0;
                  running_sum_in = 8'd0;
                  ack_index_in   = 3'd0;
                  kind_in        = nfc_rfr_pkg::KIND_DONE;
                  plen_in        = payload_len;
               end
            end
            default: begin
               // first preamble byte, also any unused phase code
               if (in_byte_ff != nfc_rfr_pkg::PREAMBLE_BYTE) begin
                  fail      = 1'b1;
                  status_in = nfc_rfr_pkg::STAT_INVALID;
               end else begin
                  phase_in = nfc_rfr_pkg::PH_PRE1;
               end
            end
         endcase
      end

      // any failure drops the frame and waits for a new preamble
      if (fail) begin
         phase_in       = nfc_rfr_pkg::PH_PRE0;
         length_byte_in = 8'd0;
         remaining_in   = 8'd0;
         running_sum_in = 8'd0;
         ack_index_in   = 3'd0;
         kind_in        = nfc_rfr_pkg::KIND_FAIL;
         data_in        = 8'd0;
         plen_in        = 8'd0;
      end
   end

   // configuration registers and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_command_ff <= nfc_rfr_pkg::EXPECTED_COMMAND_RESET;
         buffer_capacity_ff  <= nfc_rfr_pkg::BUFFER_CAPACITY_RESET;
         expect_ack_ff       <= 1'b0;
         phase_ff            <= nfc_rfr_pkg::PH_PRE0;
         length_byte_ff      <= 8'd0;
         remaining_ff        <= 8'd0;
         running_sum_ff      <= 8'd0;
         ack_index_ff        <= 3'd0;
      end else if (csr_write && csr_index == nfc_rfr_pkg::CSR_EXPECT_ACK) begin
         // mode change restarts reception
         expect_ack_ff  <= csr_data[0];
         phase_ff       <= nfc_rfr_pkg::PH_PRE0;
         length_byte_ff <= 8'd0;
         remaining_ff   <= 8'd0;
         running_sum_ff <= 8'd0;
         ack_index_ff   <= 3'd0;
      end else begin
         if (csr_write && csr_index == nfc_rfr_pkg::CSR_EXPECTED_COMMAND) begin
            expected_command_ff <= csr_data;
         end
         if (csr_write && csr_index == nfc_rfr_pkg::CSR_BUFFER_CAPACITY) begin
            buffer_capacity_ff <= csr_data;
         end
         if (advance) begin
            phase_ff       <= phase_in;
            length_byte_ff <= length_byte_in;
            remaining_ff   <= remaining_in;
            running_sum_ff <= running_sum_in;
            ack_index_ff   <= ack_index_in;
         end
      end
   end

   // input register: hold the request until the result slot takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         status_ff <= status_in;
         plen_ff   <= plen_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_status         = status_ff;
   assign rsp_payload_length = plen_ff;

endmodule

>>> tb/testbench.sv
// Self-checking regression of the NFC response frame receiver with its own frame parser model.
`timescale 1ns / 1ps

module testbench;

   // Clock period is 2 ns; the run is cut off well beyond the slowest legal run.
   localparam int        RUN_LIMIT_NS     = 2_000_000;
   localparam int        LONG_HOLD_CYCLES = 300;
   localparam int        DRAIN_CYCLES     = 4;
   localparam int        MAX_REPORTS      = 50;
   // Acknowledge bytes in arrival order, first byte in the top octet
   localparam logic [47:0] ACK_SEQUENCE   = 48'h00_00_FF_00_FF_00;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic [7:0] payload_length;
   } frame_response_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } rx_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = nfc_rfr_pkg::ACT_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [2:0] rsp_status;
   logic [7:0] rsp_payload_length;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = nfc_rfr_pkg::CSR_EXPECTED_COMMAND;
   logic [7:0] csr_data = 8'h00;

   nfc_response_frame_receiver uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_status         (rsp_status),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Model copy of the configuration registers
   logic [7:0] cfg_command  = nfc_rfr_pkg::EXPECTED_COMMAND_RESET;
   logic [7:0] cfg_capacity = nfc_rfr_pkg::BUFFER_CAPACITY_RESET;
   logic       cfg_ack_mode = 1'b0;

   // Model copy of the parser state
   logic [3:0] frm_phase     = nfc_rfr_pkg::PH_PRE0;
   logic [7:0] frm_length    = 8'h00;
   logic [7:0] frm_remaining = 8'h00;
   logic [7:0] frm_sum       = 8'h00;   // ack mode: mismatch flag
   logic [2:0] frm_ack_pos   = 3'd0;

   frame_response_type pending_responses[$];
   rx_item_type        frame_items[$];

   int requests_sent  = 0;
   int mismatch_count = 0;

   // Idle knobs: percent chance of a gap per request / of a stall per cycle
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   // Long receiver hold-offs: the test bumps hold_asked, the ready process serves it
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int stall_left    = 0;

   // ---------------------------------------------------------------------------------
   // Frame parser model
   // ---------------------------------------------------------------------------------

   function automatic void restart_parser();
      frm_phase     = nfc_rfr_pkg::PH_PRE0;
      frm_length    = 8'h00;
      frm_remaining = 8'h00;
      frm_sum       = 8'h00;
      frm_ack_pos   = 3'd0;
   endfunction

   function automatic frame_response_type make_response(logic [1:0] kind, logic [7:0] data,
                                                        logic [2:0] status,
                                                        logic [7:0] plen);
      frame_response_type r;
      r.kind           = kind;
      r.data_byte      = data;
      r.status         = status;
      r.payload_length = plen;
      return r;
   endfunction

   function automatic frame_response_type frame_fail(logic [2:0] status);
      restart_parser();
      return make_response(nfc_rfr_pkg::KIND_FAIL, 8'h00, status, 8'h00);
   endfunction

   // Advance the model by one request and return the response it must produce.
   function automatic frame_response_type next_response(logic act, logic [7:0] b);
      logic [7:0] cmd_plus;
      logic [7:0] sum8;
      logic [7:0] plen;
      logic [2:0] pos;
      cmd_plus = cfg_command + 8'd1;
      if (act == nfc_rfr_pkg::ACT_TIMEOUT)
         return frame_fail(nfc_rfr_pkg::STAT_TIMEOUT);

      if (cfg_ack_mode) begin
         pos = (frm_ack_pos >= nfc_rfr_pkg::ACK_LEN) ? 3'd0 : frm_ack_pos;
         if (b != ACK_SEQUENCE[47 - 8 * pos -: 8])
            frm_sum = 8'd1;
         pos = pos + 3'd1;
         if (pos < nfc_rfr_pkg::ACK_LEN) begin
            frm_ack_pos = pos;
            return make_response(nfc_rfr_pkg::KIND_PROGRESS, 8'h00,
                                 nfc_rfr_pkg::STAT_OK, 8'h00);
         end
         if (frm_sum != 8'h00)
            return frame_fail(nfc_rfr_pkg::STAT_BAD_ACK);
         restart_parser();
         return make_response(nfc_rfr_pkg::KIND_DONE, 8'h00, nfc_rfr_pkg::STAT_OK, 8'h00);
      end

      case (frm_phase)
         nfc_rfr_pkg::PH_PRE1: begin
            if (b != nfc_rfr_pkg::PREAMBLE_BYTE) return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_phase = nfc_rfr_pkg::PH_START;
         end
         nfc_rfr_pkg::PH_START: begin
            if (b != nfc_rfr_pkg::START_CODE_BYTE)
               return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_phase = nfc_rfr_pkg::PH_LEN;
         end
         nfc_rfr_pkg::PH_LEN: begin
            frm_length = b;
            frm_phase  = nfc_rfr_pkg::PH_LCS;
         end
         nfc_rfr_pkg::PH_LCS: begin
            sum8 = frm_length + b;
            if (sum8 != 8'h00 || frm_length < nfc_rfr_pkg::LEN_OVERHEAD)
               return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_remaining = frm_length - nfc_rfr_pkg::LEN_OVERHEAD;
            if (frm_remaining > cfg_capacity) return frame_fail(nfc_rfr_pkg::STAT_NO_SPACE);
            frm_phase = nfc_rfr_pkg::PH_TFI;
         end
         nfc_rfr_pkg::PH_TFI: begin
            if (b != nfc_rfr_pkg::DIR_TO_HOST) return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_phase = nfc_rfr_pkg::PH_CMD;
         end
         nfc_rfr_pkg::PH_CMD: begin
            if (b != cmd_plus) return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_sum   = nfc_rfr_pkg::DIR_TO_HOST + cmd_plus;
            frm_phase = (frm_remaining != 8'h00) ? nfc_rfr_pkg::PH_DATA : nfc_rfr_pkg::PH_DCS;
         end
         nfc_rfr_pkg::PH_DATA: begin
            // Payload goes out before the checksum is known
            frm_sum       = frm_sum + b;
            frm_remaining = frm_remaining - 8'd1;
            if (frm_remaining == 8'h00) frm_phase = nfc_rfr_pkg::PH_DCS;
            return make_response(nfc_rfr_pkg::KIND_PAYLOAD, b, nfc_rfr_pkg::STAT_OK, 8'h00);
         end
         nfc_rfr_pkg::PH_DCS: begin
            frm_sum   = frm_sum + b;
            frm_phase = nfc_rfr_pkg::PH_POST;
         end
         nfc_rfr_pkg::PH_POST: begin
            plen = frm_length - nfc_rfr_pkg::LEN_OVERHEAD;
            if (frm_sum != 8'h00 || b != nfc_rfr_pkg::POSTAMBLE_BYTE)
               return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            restart_parser();
            return make_response(nfc_rfr_pkg::KIND_DONE, 8'h00, nfc_rfr_pkg::STAT_OK, plen);
         end
         default: begin
            // Unused phase codes behave as waiting for the first preamble byte
            if (b != nfc_rfr_pkg::PREAMBLE_BYTE) return frame_fail(nfc_rfr_pkg::STAT_INVALID);
            frm_phase = nfc_rfr_pkg::PH_PRE1;
         end
      endcase
      return make_response(nfc_rfr_pkg::KIND_PROGRESS, 8'h00, nfc_rfr_pkg::STAT_OK, 8'h00);
   endfunction

   // ---------------------------------------------------------------------------------
   // Response side: ready with random stalls, and the checker
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_asked) begin
         // Start a long hold-off so that the block fills up and stalls its input
         hold_served = hold_asked;
         hold_left   = LONG_HOLD_CYCLES - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Compare every accepted response with the oldest expectation, field by field.
   always @(posedge clock) begin : check_responses
      frame_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_data_byte !== want.data_byte)
               report_mismatch($sformatf("data_byte %02h, want %02h",
                                         rsp_data_byte, want.data_byte));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_payload_length !== want.payload_length)
               report_mismatch($sformatf("payload_length %0d, want %0d",
                                         rsp_payload_length, want.payload_length));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   function automatic int pick_request_gap();
      if ($urandom_range(0, 99) >= req_gap_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Offer one request, hold it until taken, then predict its response.
   task automatic send_request(input logic act, input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(next_response(act, b));
      requests_sent++;
      gap = pick_request_gap();
      // Keep valid high for back-to-back requests; drop it only for a gap
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         nfc_rfr_pkg::CSR_EXPECTED_COMMAND: cfg_command = value;
         nfc_rfr_pkg::CSR_BUFFER_CAPACITY:  cfg_capacity = value;
         nfc_rfr_pkg::CSR_EXPECT_ACK: begin
            cfg_ack_mode = value[0];
            restart_parser();
         end
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b);
      rx_item_type it;
      it.action  = nfc_rfr_pkg::ACT_BYTE;
      it.rx_byte = b;
      frame_items.push_back(it);
   endtask

   task automatic push_timeout();
      rx_item_type it;
      it.action  = nfc_rfr_pkg::ACT_TIMEOUT;
      it.rx_byte = 8'($urandom_range(0, 255));
      frame_items.push_back(it);
   endtask

   task automatic send_frame();
      rx_item_type it;
      while (frame_items.size() != 0) begin
         it = frame_items.pop_front();
         send_request(it.action, it.rx_byte);
      end
   endtask

   // Queue a well-formed response frame carrying plen random payload bytes.
   task automatic build_response_frame(input int plen, input logic [7:0] cmd_byte);
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] b;
      len = 8'(plen) + nfc_rfr_pkg::LEN_OVERHEAD;
      sum = nfc_rfr_pkg::DIR_TO_HOST + cmd_byte;
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::START_CODE_BYTE);
      push_byte(len);
      push_byte(8'h00 - len);
      push_byte(nfc_rfr_pkg::DIR_TO_HOST);
      push_byte(cmd_byte);
      for (int i = 0; i < plen; i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         push_byte(b);
      end
      push_byte(8'h00 - sum);
      push_byte(nfc_rfr_pkg::POSTAMBLE_BYTE);
   endtask

   task automatic build_ack_frame();
      for (int i = 0; i < 6; i++)
         push_byte(ACK_SEQUENCE[47 - 8 * i -: 8]);
   endtask

   // Break the queued frame: flip bits of one byte, or cut it short with a timeout.
   task automatic mangle_frame();
      int pos;
      rx_item_type it;
      pos = $urandom_range(0, frame_items.size() - 1);
      it  = frame_items[pos];
      if ($urandom_range(0, 3) == 0) begin
         it.action = nfc_rfr_pkg::ACT_TIMEOUT;
         frame_items[pos] = it;
         while (frame_items.size() > pos + 1)
            it = frame_items.pop_back();
      end else begin
         it.rx_byte = it.rx_byte ^ 8'($urandom_range(1, 255));
         frame_items[pos] = it;
      end
   endtask

   task automatic build_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) push_timeout();
         else push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Now and then switch both sides between idling patterns, including none at all.
   task automatic shuffle_idling();
      int pct_choice[3] = '{0, 25, 60};
      if ($urandom_range(0, 15) == 0) begin
         req_gap_pct   = pct_choice[$urandom_range(0, 2)];
         rsp_stall_pct = pct_choice[$urandom_range(0, 2)];
      end
   endtask

   // Mostly good frames with random content, plus broken frames, bad headers and noise.
   task automatic run_response_frames(input int count, input int max_plen);
      int start;
      int pick;
      int plen;
      logic [7:0] len;
      start = requests_sent;
      while (requests_sent - start < count) begin
         shuffle_idling();
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_plen)
                                            : $urandom_range(0, 4);
         if (pick < 65) begin
            build_response_frame(plen, cfg_command + 8'd1);
         end else if (pick < 82) begin
            build_response_frame(plen, cfg_command + 8'd1);
            mangle_frame();
         end else if (pick < 86) begin
            // Wrong command code in an otherwise sound frame
            build_response_frame(plen, cfg_command + 8'($urandom_range(2, 256)));
         end else if (pick < 94) begin
            // Header only, any length byte; usually a matching checksum
            len = 8'($urandom_range(0, 255));
            push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
            push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
            push_byte(nfc_rfr_pkg::START_CODE_BYTE);
            push_byte(len);
            push_byte(($urandom_range(0, 3) != 0) ? 8'h00 - len : 8'($urandom_range(0, 255)));
         end else begin
            build_noise();
         end
         send_frame();
      end
   endtask

   task automatic run_ack_frames(input int count);
      int start;
      int pick;
      start = requests_sent;
      while (requests_sent - start < count) begin
         shuffle_idling();
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            build_ack_frame();
         end else if (pick < 92) begin
            build_ack_frame();
            mangle_frame();
         end else begin
            build_noise();
         end
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Timeout, bad preamble, short length, no space and the smallest good frame
   task automatic test_directed_response();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      push_timeout();
      push_byte(8'hFF);
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::START_CODE_BYTE);
      push_byte(8'h01);
      push_byte(8'hFF);
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::PREAMBLE_BYTE);
      push_byte(nfc_rfr_pkg::START_CODE_BYTE);
      push_byte(8'h50);
      push_byte(8'hB0);
      build_response_frame(0, cfg_command + 8'd1);
      send_frame();
      wait_until_drained();
   endtask

   // Good acknowledge, one with a wrong last byte, and a timeout part way through
   task automatic test_directed_ack();
      write_register(nfc_rfr_pkg::CSR_EXPECT_ACK, 8'h01);
      build_ack_frame();
      build_ack_frame();
      frame_items[frame_items.size() - 1].rx_byte = 8'h01;
      push_byte(8'h00);
      push_byte(8'h00);
      push_timeout();
      send_frame();
      wait_until_drained();
      write_register(nfc_rfr_pkg::CSR_EXPECT_ACK, 8'h00);
   endtask

   task automatic test_random_response();
      write_register(nfc_rfr_pkg::CSR_EXPECTED_COMMAND, 8'($urandom_range(0, 254)));
      write_register(nfc_rfr_pkg::CSR_BUFFER_CAPACITY, 8'd32);
      req_gap_pct   = 25;
      rsp_stall_pct = 25;
      run_response_frames(300, 40);
      wait_until_drained();
   endtask

   // Command code that wraps to zero, full and zero capacity, and the longest frames
   task automatic test_extreme_settings();
      write_register(nfc_rfr_pkg::CSR_EXPECTED_COMMAND, 8'hFF);
      write_register(nfc_rfr_pkg::CSR_BUFFER_CAPACITY, 8'hFF);
      build_response_frame(253, 8'h00);
      build_response_frame(253, 8'h00);
      send_frame();
      run_response_frames(100, 24);
      wait_until_drained();
      write_register(nfc_rfr_pkg::CSR_BUFFER_CAPACITY, 8'h00);
      write_register(nfc_rfr_pkg::CSR_EXPECTED_COMMAND, 8'h00);
      run_response_frames(150, 3);
      wait_until_drained();
   endtask

   task automatic test_ack_mode();
      write_register(nfc_rfr_pkg::CSR_EXPECT_ACK, 8'h01);
      run_ack_frames(300);
      wait_until_drained();
      write_register(nfc_rfr_pkg::CSR_EXPECT_ACK, 8'h00);
      write_register(nfc_rfr_pkg::CSR_BUFFER_CAPACITY, 8'd16);
   endtask

   // Hold the receiver off while requests keep coming and drain; repeat with random stalls.
   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_asked    = hold_asked + 1;
      run_response_frames(120, 20);
      wait_until_drained();
      req_gap_pct   = 25;
      rsp_stall_pct = 60;
      run_response_frames(120, 20);
      wait_until_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_response();
      test_directed_ack();
      test_random_response();
      test_extreme_settings();
      test_ack_mode();
      test_backpressure();
      if (mismatch_count == 0)
         $display("nfc_response_frame_receiver regression: pass");
      else
         $display("nfc_response_frame_receiver regression: fail");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("nfc_response_frame_receiver regression: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/nfc_rfr_pkg.sv
rtl/nfc_response_frame_receiver.sv
tb/testbench.sv
